// File: hdl/timed_switch_step_sequencer_unit_macros.svh
// assertion macros shared by the sequencer rtl
`ifndef TIMED_SWITCH_STEP_SEQUENCER_UNIT_MACROS_SVH
`define TIMED_SWITCH_STEP_SEQUENCER_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define TSS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never hold outside reset
`define TSS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `TSS_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// File: hdl/tss_pkg.sv
package tss_pkg;

  localparam int unsigned MaxSteps     = 64;
  localparam int unsigned StepAddrW    = $clog2(MaxSteps);
  localparam int unsigned TicksW       = 29;
  localparam logic [6:0]  HundredthsMax = 7'd99;
  localparam logic [31:0] OnDelay      = 32'd5;
  localparam logic [31:0] EndDelay     = 32'd10;
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_SET_SEC   = 2'd2,
    ACT_ARM       = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_DONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_OFF = 2'd0,
    PH_ON  = 2'd1,
    PH_END = 2'd2
  } phase_e;

  typedef enum logic {
    REG_START_TIME = 1'b0,
    REG_STEP_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  step_index;
    logic [31:0] step_offset_ms;
    logic [7:0]  off_pattern_a;
    logic [7:0]  off_pattern_c;
    logic [7:0]  on_pattern_a;
    logic [7:0]  on_pattern_c;
    logic [31:0] seconds_value;
  } in_t;

  typedef struct packed {
    logic [7:0] port_a;
    logic [7:0] port_c;
    logic       strobe_off;
    logic       strobe_on;
    logic [1:0] run_state;
    logic [6:0] current_step;
  } out_t;

  // table entry keeps the offset already scaled to 10 ms ticks
  typedef struct packed {
    logic [TicksW-1:0] ticks;
    logic [7:0]        off_a;
    logic [7:0]        off_c;
    logic [7:0]        on_a;
    logic [7:0]        on_c;
  } entry_t;

  // exact floor(x / 10) for any 32-bit x
  function automatic logic [TicksW-1:0] div10(input logic [31:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(Recip10);
    return p[63:35];
  endfunction

endpackage

// File: hdl/tss_step_mem.sv
module tss_step_mem (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [tss_pkg::StepAddrW-1:0]      waddr_i,
  input  tss_pkg::entry_t                    wdata_i,
  input  logic [tss_pkg::StepAddrW-1:0]      raddr_i,
  output tss_pkg::entry_t                    rdata_o
);
  import tss_pkg::*;

  entry_t mem [MaxSteps];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-first: a write to the address being read shows up at once
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rd_q <= wdata_i;
    end else begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

// File: hdl/timed_switch_step_sequencer_unit.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+----------------------------
// input     | in        | in_valid_i/in_ready_o | in_item_i (tss_pkg::in_t)
// result    | out       | out_valid_o/out_ready_i | out_item_o (tss_pkg::out_t)
// config    | in        | apb, pready always 1  | 0x0 start_time_sec, 0x4 step_count
//
// one item per cycle sustained while out_ready_i is high; an item first sits in the input register,
// then its result sits in the output register
// the step table is a 64-entry memory with a registered read that follows the
// current step pointer; the offset is divided by 10 on the way into the table
// reset clears all control state; the table holds garbage until written
// a stalled result blocks the input register only once both stages are full
`include "timed_switch_step_sequencer_unit_macros.svh"

module timed_switch_step_sequencer_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tss_pkg::in_t    in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tss_pkg::out_t   out_item_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import tss_pkg::*;

  // configuration
  logic [31:0] start_time_q;
  logic [6:0]  step_count_q;
  logic        cfg_we;
  reg_e        cfg_sel;

  // pipeline
  logic  in_valid_q;
  in_t   in_q;
  logic  out_valid_q;
  out_t  out_q;
  logic  fire;

  // sequencer state
  logic [31:0]       sec_q, sec_d;
  logic [6:0]        hund_q, hund_d;
  logic [31:0]       rt_q, rt_d;
  mode_e             mode_q, mode_d;
  phase_e            phase_q, phase_d;
  logic [6:0]        sp_q, sp_d;
  logic [TicksW-1:0] off_q, off_d;
  logic              pend_q, pend_d;
  logic [7:0]        pa_q, pa_d;
  logic [7:0]        pc_q, pc_d;
  logic              so_q, so_d;
  logic              son_q, son_d;

  // table
  entry_t            wr_entry;
  logic              tbl_we;
  entry_t            rd_entry;
  entry_t            e0_q;

  // tick datapath
  logic [6:0]        hund_inc;
  logic [31:0]       sec_tick;
  logic              start;
  logic              running;
  entry_t            cur;
  logic [TicksW-1:0] off_cur;
  logic [TicksW-1:0] off_use;
  logic [31:0]       now;
  logic [31:0]       off_ext;
  logic [6:0]        sp_inc;
  logic [6:0]        cnt_use;

  // ---------------- apb ----------------
  assign pready  = 1'b1;
  assign cfg_sel = reg_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (cfg_sel)
      REG_START_TIME: prdata = start_time_q;
      REG_STEP_COUNT: prdata = {25'd0, step_count_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      step_count_q <= '0;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_START_TIME: start_time_q <= pwdata;
        REG_STEP_COUNT: step_count_q <= pwdata[6:0];
        default:        ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (fire) begin
      out_q <= '{port_a:       pa_d,
                 port_c:       pc_d,
                 strobe_off:   so_d,
                 strobe_on:    son_d,
                 run_state:    mode_d,
                 current_step: sp_d};
    end
  end

  // ---------------- step table ----------------
  assign wr_entry = '{ticks: div10(in_q.step_offset_ms),
                      off_a: in_q.off_pattern_a,
                      off_c: in_q.off_pattern_c,
                      on_a:  in_q.on_pattern_a,
                      on_c:  in_q.on_pattern_c};
  assign tbl_we   = fire && (action_e'(in_q.action) == ACT_WRITE);

  tss_step_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (in_q.step_index),
    .wdata_i (wr_entry),
    .raddr_i (sp_d[StepAddrW-1:0]),
    .rdata_o (rd_entry)
  );

  // copy of entry 0, needed on the tick that starts a run
  always_ff @(posedge clk_i) begin
    if (tbl_we && (in_q.step_index == '0)) begin
      e0_q <= wr_entry;
    end
  end

  // ---------------- sequencer ----------------
  assign hund_inc = hund_q + 7'd1;
  assign sec_tick = (hund_q == HundredthsMax) ? sec_q + 32'd1 : sec_q;
  assign start    = (mode_q == MODE_WAIT) && (sec_tick >= start_time_q);
  assign running  = start || (mode_q == MODE_RUN);
  // offset of a freshly loaded step is taken from the read port in the cycle after the step advance
  assign off_cur  = pend_q ? rd_entry.ticks : off_q;
  assign cur      = start ? e0_q : rd_entry;
  assign off_use  = start ? e0_q.ticks : off_cur;
  assign now      = start ? 32'd1 : rt_q + 32'd1;
  assign off_ext  = 32'(off_use);
  assign sp_inc   = sp_q + 7'd1;
  assign cnt_use  = (step_count_q > 7'(MaxSteps)) ? 7'(MaxSteps) : step_count_q;

  always_comb begin
    sec_d   = sec_q;
    hund_d  = hund_q;
    rt_d    = rt_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    sp_d    = sp_q;
    off_d   = off_cur;
    pend_d  = 1'b0;
    pa_d    = pa_q;
    pc_d    = pc_q;
    so_d    = so_q;
    son_d   = son_q;
    if (fire) begin
      case (action_e'(in_q.action))
        ACT_TICK: begin
          sec_d  = sec_tick;
          hund_d = (hund_q == HundredthsMax) ? 7'd0 : hund_inc;
          if (start) begin
            mode_d  = MODE_RUN;
            sp_d    = '0;
            phase_d = PH_OFF;
            off_d   = e0_q.ticks;
          end
          if (running) begin
            rt_d = now;
            case (start ? PH_OFF : phase_q)
              PH_OFF: begin
                if (now >= off_ext) begin
                  pa_d    = cur.off_a;
                  pc_d    = cur.off_c;
                  so_d    = 1'b1;
                  phase_d = PH_ON;
                end
              end
              PH_ON: begin
                if (now >= off_ext + OnDelay) begin
                  so_d    = 1'b0;
                  pa_d    = cur.on_a;
                  pc_d    = cur.on_c;
                  son_d   = 1'b1;
                  phase_d = PH_END;
                end
              end
              default: begin
                if (now >= off_ext + EndDelay) begin
                  son_d   = 1'b0;
                  phase_d = PH_OFF;
                  sp_d    = sp_inc;
                  if (sp_inc < cnt_use) begin
                    pend_d = 1'b1;
                  end else begin
                    mode_d = MODE_DONE;
                  end
                end
              end
            endcase
          end
        end
        ACT_SET_SEC: sec_d = in_q.seconds_value;
        ACT_ARM: begin
          mode_d = MODE_WAIT;
          so_d   = 1'b0;
          son_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= '0;
      hund_q  <= '0;
      rt_q    <= '0;
      mode_q  <= MODE_IDLE;
      phase_q <= PH_OFF;
      sp_q    <= '0;
      off_q   <= '0;
      pend_q  <= 1'b0;
      pa_q    <= '0;
      pc_q    <= '0;
      so_q    <= 1'b0;
      son_q   <= 1'b0;
    end else begin
      sec_q   <= sec_d;
      hund_q  <= hund_d;
      rt_q    <= rt_d;
      mode_q  <= mode_d;
      phase_q <= phase_d;
      sp_q    <= sp_d;
      off_q   <= off_d;
      pend_q  <= pend_d;
      pa_q    <= pa_d;
      pc_q    <= pc_d;
      so_q    <= so_d;
      son_q   <= son_d;
    end
  end

  // ---------------- checks ----------------
  `TSS_ASSERT_NEVER(a_strobes_excl, clk_i, rst_ni, so_q && son_q, "both strobes high")
  `TSS_ASSERT(a_run_ptr, clk_i, rst_ni, (mode_q == MODE_RUN) |-> (sp_q < 7'(MaxSteps)), "step pointer past table while running")
  `TSS_ASSERT(a_load_phase, clk_i, rst_ni, pend_q |-> (phase_q == PH_OFF) && $past(fire), "step load without a completed step")

endmodule
